>>> design/fnvkb_pkg.sv
`timescale 1ns / 1ps

package fnvkb_pkg;

    localparam int unsigned HASH_W   = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STEP_W   = $clog2(HASH_W);

    localparam logic [HASH_W-1:0] FNV_PRIME        = 32'd16777619;
    localparam logic [HASH_W-1:0] FNV_BASIS        = 32'd2166136261;
    localparam logic [HASH_W-1:0] BUCKETS_AT_RESET = 32'd512;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

>>> design/fnv1a_key_bucket_index.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// s_        in   s_valid / s_ready    s_key_byte[7:0]
// m_        out  m_valid / m_ready    m_bucket_index[31:0], m_full_hash[31:0]
// cfg_      in   cfg_wr_en            cfg_wr_data[31:0] (bucket count)
//
// Non-zero key byte: hash update at the accept edge.
// Zero byte (key end): its beat, then the restoring subtractor for the bucket remainder
// (ST_DIV), then the load of the output register (ST_FINISH); the next byte is taken
// after that load at the earliest, and the load waits while the previous result is still waiting.
// A waiting result does not block key bytes once the remainder is loaded.
// aresetn (synchronous, active low) loads the basis and a count of 512.
module fnv1a_key_bucket_index (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_key_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_bucket_index,
    output logic [31:0] m_full_hash,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    fnvkb_pkg::state_t state_reg, state_next;

    logic [fnvkb_pkg::HASH_W-1:0] hash_reg, hash_next;
    logic [fnvkb_pkg::HASH_W-1:0] bucket_count_reg;
    logic [fnvkb_pkg::HASH_W-1:0] key_hash_reg, key_hash_next;
    logic [fnvkb_pkg::HASH_W-1:0] dvd_reg, dvd_next;
    logic [fnvkb_pkg::HASH_W-1:0] rem_reg, rem_next;
    logic [fnvkb_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                         m_valid_reg, m_valid_next;
    logic [fnvkb_pkg::HASH_W-1:0] m_bucket_index_reg, m_bucket_index_next;
    logic [fnvkb_pkg::HASH_W-1:0] m_full_hash_reg, m_full_hash_next;

    logic                         s_beat;
    logic                         out_free;
    logic [fnvkb_pkg::HASH_W:0]   trial;
    logic [fnvkb_pkg::HASH_W:0]   diff;

    assign s_ready        = (state_reg == fnvkb_pkg::ST_IDLE);
    assign s_beat         = s_valid && s_ready;
    assign out_free       = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_bucket_index = m_bucket_index_reg;
    assign m_full_hash    = m_full_hash_reg;

    // one restoring step
    assign trial = {rem_reg, dvd_reg[fnvkb_pkg::HASH_W-1]};
    assign diff  = trial - {1'b0, bucket_count_reg};

    always_comb begin
        state_next          = state_reg;
        hash_next           = hash_reg;
        key_hash_next       = key_hash_reg;
        dvd_next            = dvd_reg;
        rem_next            = rem_reg;
        cnt_next            = cnt_reg;
        m_valid_next        = m_valid_reg;
        m_bucket_index_next = m_bucket_index_reg;
        m_full_hash_next    = m_full_hash_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            fnvkb_pkg::ST_IDLE: begin
                if (s_beat) begin
                    if (s_key_byte != '0) begin
                        hash_next = (hash_reg ^ {{(fnvkb_pkg::HASH_W-fnvkb_pkg::BYTE_W){1'b0}},
                                                 s_key_byte}) * fnvkb_pkg::FNV_PRIME;
                    end else begin
                        key_hash_next = hash_reg;
                        dvd_next      = hash_reg;
                        rem_next      = '0;
                        cnt_next      = '0;
                        hash_next     = fnvkb_pkg::FNV_BASIS;
                        state_next    = fnvkb_pkg::ST_DIV;
                    end
                end
            end
            fnvkb_pkg::ST_DIV: begin
                if (trial >= {1'b0, bucket_count_reg}) begin
                    rem_next = diff[fnvkb_pkg::HASH_W-1:0];
                end else begin
                    rem_next = trial[fnvkb_pkg::HASH_W-1:0];
                end
                dvd_next = {dvd_reg[fnvkb_pkg::HASH_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == fnvkb_pkg::STEP_W'(fnvkb_pkg::HASH_W - 1)) begin
                    state_next = fnvkb_pkg::ST_FINISH;
                end
            end
            fnvkb_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_bucket_index_next = rem_reg;
                    m_full_hash_next    = key_hash_reg;
                    state_next          = fnvkb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fnvkb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= fnvkb_pkg::ST_IDLE;
            hash_reg         <= fnvkb_pkg::FNV_BASIS;
            bucket_count_reg <= fnvkb_pkg::BUCKETS_AT_RESET;
            cnt_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hash_reg    <= hash_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                bucket_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_hash_reg       <= key_hash_next;
        dvd_reg            <= dvd_next;
        rem_reg            <= rem_next;
        m_bucket_index_reg <= m_bucket_index_next;
        m_full_hash_reg    <= m_full_hash_next;
    end

    a_end_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_key_byte == '0) |=> (state_reg == fnvkb_pkg::ST_DIV && cnt_reg == '0))
        else $error("key end did not start the remainder");

    a_finish_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fnvkb_pkg::ST_FINISH && out_free) |=> (m_valid && s_ready))
        else $error("finished remainder not loaded");

    a_byte_keeps_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_key_byte != '0) |=> (s_ready && $stable(m_full_hash)))
        else $error("key byte disturbed result");

    a_idle_cnt_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fnvkb_pkg::ST_FINISH) |-> (cnt_reg == '0))
        else $error("step count not wrapped");

endmodule
